// ===== rtl/atf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ATA taskfile sequencer package
// Shared types, register codes and reset values for the taskfile sequencer.
// ----------------------------------------------------------------------------
package atf_pkg;

  // Taskfile register indexes as seen on the result stream.
  localparam logic [2:0] REG_FEATURES = 3'd1;
  localparam logic [2:0] REG_COUNT    = 3'd2;
  localparam logic [2:0] REG_LBA_LOW  = 3'd3;
  localparam logic [2:0] REG_LBA_MID  = 3'd4;
  localparam logic [2:0] REG_LBA_HIGH = 3'd5;
  localparam logic [2:0] REG_DEV_HEAD = 3'd6;
  localparam logic [2:0] REG_COMMAND  = 3'd7;

  // Addressing modes.
  localparam logic [1:0] MODE_CHS   = 2'd0;
  localparam logic [1:0] MODE_LBA28 = 2'd1;

  // Configuration register indexes (byte address / 4).
  localparam logic [2:0] CFG_IDX_MODE  = 3'd0;
  localparam logic [2:0] CFG_IDX_SLAVE = 3'd1;
  localparam logic [2:0] CFG_IDX_LBA   = 3'd2;
  localparam logic [2:0] CFG_IDX_HEADS = 3'd3;
  localparam logic [2:0] CFG_IDX_SPT   = 3'd4;

  // Configuration reset values.
  localparam logic [1:0] CFG_RST_MODE  = MODE_LBA28;
  localparam logic       CFG_RST_SLAVE = 1'b0;
  localparam logic       CFG_RST_LBA   = 1'b1;
  localparam logic [4:0] CFG_RST_HEADS = 5'd16;
  localparam logic [7:0] CFG_RST_SPT   = 8'd63;

  // Device/head base bytes and masks.
  localparam logic [7:0] DH_CHS_MASTER = 8'hA0;
  localparam logic [7:0] DH_CHS_SLAVE  = 8'hB0;
  localparam logic [7:0] DH_LBA_MASTER = 8'hE0;
  localparam logic [7:0] DH_LBA_SLAVE  = 8'hF0;
  localparam logic [7:0] DH_HEAD_MASK  = 8'h0F;
  localparam logic [7:0] DH_LBA_BIT    = 8'h40;

  // Default depth of the job queue between front and back.
  localparam int ATF_QUEUE_DEPTH = 2;

  // Kind of register-write run a job produces.
  typedef enum logic [1:0] {
    JOB_SELECT,
    JOB_SEVEN,
    JOB_LBA48
  } job_kind_t;

  // One classified command, ready for the back end to play out.
  // For seven-write jobs b0/b1/b2 are the low/mid/high bytes.
  // For LBA48 jobs b0..b3 are the address bytes, lowest first.
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] dev_head;
    logic [7:0] count;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] feature;
    logic [7:0] command;
  } job_t;

  // Live configuration handed to the front end.
  typedef struct packed {
    logic [1:0] address_mode;
    logic       slave_drive;
    logic       lba_capable;
    logic [4:0] head_count;
    logic [7:0] sectors_per_track;
  } cfg_t;

endpackage : atf_pkg
`default_nettype wire

// ===== rtl/ata_taskfile_sequencer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A CHS command passes through two divisions on the front end's
// two-bit-per-cycle divider before it is queued; select and LBA commands
// go to the queue directly. The front takes a new item only once the last
// one has been pushed or dropped; the back plays out one write per cycle
// while out_tready holds (1, 7 or 10 writes per item).
// Reset: configuration returns to its defaults, the shadow byte clears to 0
// and the job queue and output stage empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
// ATA taskfile sequencer top level
// Turns command and drive-select beats into ordered taskfile register writes,
// with an APB-style port for the addressing and geometry registers.
// ----------------------------------------------------------------------------
module ata_taskfile_sequencer_top
  import atf_pkg::*;
#(
  parameter int QUEUE_DEPTH = ATF_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Command stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // command_code, block_address, sector_total,
                                       // feature_byte, select_value (low to high)
  input  wire logic        in_tuser,   // action
  // Register write stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // reg_index, reg_value, zero fill (low to high)
  output logic             out_tlast,  // last_write
  // Configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  cfg_t       cfg_r, cfg_nxt;
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  logic       push;
  job_t       push_job;
  logic       pop;
  job_t       pop_job;
  logic       full;
  logic       empty;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  // Register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_idx)
        CFG_IDX_MODE:  cfg_nxt.address_mode      = cfg_pwdata[1:0];
        CFG_IDX_SLAVE: cfg_nxt.slave_drive       = cfg_pwdata[0];
        CFG_IDX_LBA:   cfg_nxt.lba_capable       = cfg_pwdata[0];
        CFG_IDX_HEADS: cfg_nxt.head_count        = cfg_pwdata[4:0];
        CFG_IDX_SPT:   cfg_nxt.sectors_per_track = cfg_pwdata[7:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (cfg_idx)
      CFG_IDX_MODE:  cfg_prdata = {30'd0, cfg_r.address_mode};
      CFG_IDX_SLAVE: cfg_prdata = {31'd0, cfg_r.slave_drive};
      CFG_IDX_LBA:   cfg_prdata = {31'd0, cfg_r.lba_capable};
      CFG_IDX_HEADS: cfg_prdata = {27'd0, cfg_r.head_count};
      CFG_IDX_SPT:   cfg_prdata = {24'd0, cfg_r.sectors_per_track};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.address_mode      <= CFG_RST_MODE;
      cfg_r.slave_drive       <= CFG_RST_SLAVE;
      cfg_r.lba_capable       <= CFG_RST_LBA;
      cfg_r.head_count        <= CFG_RST_HEADS;
      cfg_r.sectors_per_track <= CFG_RST_SPT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  atf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_job  (push_job),
    .full      (full)
  );

  atf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (full),
    .empty    (empty)
  );

  atf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop        (pop),
    .pop_job    (pop_job),
    .empty      (empty),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule : ata_taskfile_sequencer_top
`default_nettype wire

// ===== rtl/atf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ATA taskfile sequencer front end
// Accepts command beats, classifies them, runs the CHS translation on a
// two-bit-per-cycle restoring divider and pushes finished jobs to the queue.
// ----------------------------------------------------------------------------
module atf_front
  import atf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,  // command_code, block_address, sector_total,
                                      // feature_byte, select_value (low to high)
  input  wire logic        in_tuser,  // action
  output logic             push,
  output job_t             push_job,
  input  wire logic        full
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV1,
    ST_DIV2,
    ST_PUSH
  } state_t;

  state_t      state_r, state_nxt;
  job_t        job_r, job_nxt;
  logic [7:0]  shadow_r, shadow_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  dvs_r, dvs_nxt;
  logic [3:0]  cnt_r, cnt_nxt;

  logic [31:0] step_quo;
  logic [7:0]  step_rem;
  logic [7:0]  sel_v;
  logic [7:0]  chs_dh;
  logic        accept;

  // Two restoring division steps: shift one dividend bit into the
  // remainder, subtract the divisor when it fits.
  function automatic logic [39:0] div_step2(input logic [31:0] q, input logic [7:0] r,
                                            input logic [7:0] d);
    logic [8:0]  t;
    logic [31:0] qq;
    logic [7:0]  rr;
    qq = q;
    rr = r;
    for (int i = 0; i < 2; i++) begin
      t  = {rr, qq[31]};
      qq = {qq[30:0], 1'b0};
      if (t >= {1'b0, d}) begin
        rr    = 8'(t - {1'b0, d});
        qq[0] = 1'b1;
      end else begin
        rr = t[7:0];
      end
    end
    return {qq, rr};
  endfunction

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign push      = (state_r == ST_PUSH) && !full;
  assign push_job  = job_r;

  assign {step_quo, step_rem} = div_step2(quo_r, rem_r, dvs_r);

  // Select byte with the LBA bit dropped for drives without LBA.
  assign sel_v  = cfg.lba_capable ? in_tdata[63:56] : (in_tdata[63:56] & ~DH_LBA_BIT);
  assign chs_dh = (cfg.slave_drive ? DH_CHS_SLAVE : DH_CHS_MASTER)
                  | (step_rem & DH_HEAD_MASK);

  // Next-state logic.
  always_comb begin
    state_nxt  = state_r;
    job_nxt    = job_r;
    shadow_nxt = shadow_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    dvs_nxt    = dvs_r;
    cnt_nxt    = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          job_nxt.count   = in_tdata[47:40];
          job_nxt.feature = in_tdata[55:48];
          job_nxt.command = in_tdata[7:0];
          job_nxt.b0      = in_tdata[15:8];
          job_nxt.b1      = in_tdata[23:16];
          job_nxt.b2      = in_tdata[31:24];
          job_nxt.b3      = in_tdata[39:32];
          if (in_tuser) begin
            job_nxt.kind     = JOB_SELECT;
            job_nxt.dev_head = sel_v;
            if (sel_v != shadow_r) begin
              shadow_nxt = sel_v;
              state_nxt  = ST_PUSH;
            end
          end else if (cfg.address_mode[1]) begin
            job_nxt.kind = JOB_LBA48;
            state_nxt    = ST_PUSH;
          end else if (cfg.address_mode == MODE_CHS) begin
            job_nxt.kind = JOB_SEVEN;
            quo_nxt      = in_tdata[39:8];
            rem_nxt      = 8'd0;
            dvs_nxt      = (cfg.sectors_per_track == 8'd0) ? 8'd1 : cfg.sectors_per_track;
            cnt_nxt      = 4'd0;
            state_nxt    = ST_DIV1;
          end else begin
            job_nxt.kind     = JOB_SEVEN;
            job_nxt.dev_head = (cfg.slave_drive ? DH_LBA_SLAVE : DH_LBA_MASTER)
                               | ({4'd0, in_tdata[35:32]});
            shadow_nxt       = job_nxt.dev_head;
            state_nxt        = ST_PUSH;
          end
        end
      end
      // LBA / sectors per track: remainder gives the sector number.
      ST_DIV1: begin
        quo_nxt = step_quo;
        rem_nxt = step_rem;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          job_nxt.b0 = step_rem + 8'd1;
          rem_nxt    = 8'd0;
          dvs_nxt    = (cfg.head_count == 5'd0) ? 8'd1 : {3'd0, cfg.head_count};
          cnt_nxt    = 4'd0;
          state_nxt  = ST_DIV2;
        end
      end
      // Track number / heads: quotient is the cylinder, remainder the head.
      ST_DIV2: begin
        quo_nxt = step_quo;
        rem_nxt = step_rem;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          job_nxt.b1       = step_quo[7:0];
          job_nxt.b2       = step_quo[15:8];
          job_nxt.dev_head = chs_dh;
          shadow_nxt       = chs_dh;
          state_nxt        = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      shadow_r <= 8'd0;
      cnt_r    <= 4'd0;
    end else begin
      state_r  <= state_nxt;
      shadow_r <= shadow_nxt;
      cnt_r    <= cnt_nxt;
    end
    job_r <= job_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule : atf_front
`default_nettype wire

// ===== rtl/atf_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ATA taskfile sequencer job queue
// Small first-in first-out queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module atf_fifo
  import atf_pkg::*;
#(
  parameter int DEPTH = ATF_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      pop_job,
  output logic      full,
  output logic      empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("job queue read while empty");

endmodule : atf_fifo
`default_nettype wire

// ===== rtl/atf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ATA taskfile sequencer back end
// Takes one job at a time from the queue and plays out its taskfile register
// writes, one beat per cycle unless out_tready stalls it, through a registered output stage.
// ----------------------------------------------------------------------------
module atf_back
  import atf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  output logic              pop,
  input  wire job_t         pop_job,
  input  wire logic         empty,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [15:0]       out_tdata,  // reg_index, reg_value, zero fill (low to high)
  output logic              out_tlast   // last_write
);

  localparam logic [3:0] STEP_LAST_SEVEN = 4'd6;
  localparam logic [3:0] STEP_LAST_LBA48 = 4'd9;

  job_t       job_r, job_nxt;
  logic       busy_r, busy_nxt;
  logic [3:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_idx_r, out_idx_nxt;
  logic [7:0] out_val_r, out_val_nxt;
  logic       out_last_r, out_last_nxt;

  logic       slot_free;
  logic [2:0] beat_idx;
  logic [7:0] beat_val;
  logic       beat_last;

  assign slot_free  = !out_valid_r || out_tready;
  assign pop        = !busy_r && !empty;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_val_r, out_idx_r};
  assign out_tlast  = out_last_r;

  // Register write for the current step of the job.
  always_comb begin
    beat_idx  = REG_COMMAND;
    beat_val  = job_r.command;
    beat_last = 1'b0;
    case (job_r.kind)
      JOB_SELECT: begin
        beat_idx  = REG_DEV_HEAD;
        beat_val  = job_r.dev_head;
        beat_last = 1'b1;
      end
      JOB_SEVEN: begin
        beat_last = (step_r == STEP_LAST_SEVEN);
        case (step_r)
          4'd0:    begin beat_idx = REG_DEV_HEAD; beat_val = job_r.dev_head; end
          4'd1:    begin beat_idx = REG_COUNT;    beat_val = job_r.count;    end
          4'd2:    begin beat_idx = REG_LBA_LOW;  beat_val = job_r.b0;       end
          4'd3:    begin beat_idx = REG_LBA_MID;  beat_val = job_r.b1;       end
          4'd4:    begin beat_idx = REG_LBA_HIGH; beat_val = job_r.b2;       end
          4'd5:    begin beat_idx = REG_FEATURES; beat_val = job_r.feature;  end
          default: begin beat_idx = REG_COMMAND;  beat_val = job_r.command;  end
        endcase
      end
      JOB_LBA48: begin
        // High-order bytes go first, then the low-order bytes.
        beat_last = (step_r == STEP_LAST_LBA48);
        case (step_r)
          4'd0: begin
            beat_idx = REG_COUNT;
            beat_val = (job_r.count == 8'd0) ? 8'd1 : 8'd0;
          end
          4'd1:    begin beat_idx = REG_LBA_HIGH; beat_val = 8'd0;          end
          4'd2:    begin beat_idx = REG_LBA_MID;  beat_val = 8'd0;          end
          4'd3:    begin beat_idx = REG_LBA_LOW;  beat_val = job_r.b3;      end
          4'd4:    begin beat_idx = REG_COUNT;    beat_val = job_r.count;   end
          4'd5:    begin beat_idx = REG_LBA_HIGH; beat_val = job_r.b2;      end
          4'd6:    begin beat_idx = REG_LBA_MID;  beat_val = job_r.b1;      end
          4'd7:    begin beat_idx = REG_LBA_LOW;  beat_val = job_r.b0;      end
          4'd8:    begin beat_idx = REG_FEATURES; beat_val = job_r.feature; end
          default: begin beat_idx = REG_COMMAND;  beat_val = job_r.command; end
        endcase
      end
      default: begin
        beat_last = 1'b1;
      end
    endcase
  end

  // Job sequencing and output stage.
  always_comb begin
    job_nxt       = job_r;
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    if (pop) begin
      job_nxt  = pop_job;
      busy_nxt = 1'b1;
      step_nxt = 4'd0;
    end
    if (slot_free) begin
      out_valid_nxt = busy_r;
      if (busy_r) begin
        out_idx_nxt  = beat_idx;
        out_val_nxt  = beat_val;
        out_last_nxt = beat_last;
        step_nxt     = step_r + 4'd1;
        if (beat_last) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r      <= job_nxt;
    out_idx_r  <= out_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r <= STEP_LAST_LBA48))
    else $error("write step ran past the longest run");
  a_pop_starts_job: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (busy_r && step_r == 4'd0))
    else $error("job taken from queue did not start at its first write");

endmodule : atf_back
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA taskfile sequencer testbench
// Sends command and drive-select beats under many register settings. Every
// taskfile write that comes out is checked in order against a local
// prediction of the write runs and of the shadow device/head byte.
// ----------------------------------------------------------------------------
module tb;
  import atf_pkg::*;

  localparam logic       ACT_ISSUE     = 1'b0;
  localparam logic       ACT_SELECT    = 1'b1;
  localparam logic [1:0] MODE_LBA48    = 2'd2;
  localparam logic [1:0] MODE_WIDE     = 2'd3;  // only bit 1 is decoded, so this acts as LBA48
  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         SETTLE_CYCLES = 60;
  localparam int         MAX_REPORTS   = 10;
  localparam int         RAND_PHASES   = 12;
  localparam int         PHASE_ITEMS   = 40;

  // One command or drive-select request.
  typedef struct packed {
    logic        action;
    logic [7:0]  command;
    logic [31:0] lba;
    logic [7:0]  count;
    logic [7:0]  feature;
    logic [7:0]  sel_byte;
  } ata_req_t;

  // One taskfile register write.
  typedef struct packed {
    logic [2:0] index;
    logic [7:0] value;
    logic       last;
  } tf_write_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // command_code, block_address, sector_total,
                                // feature_byte, select_value (low to high)
  logic        in_tuser = 1'b0; // action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // reg_index, reg_value, zero fill (low to high)
  logic        out_tlast;       // last_write
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Mirror of the register settings and of the shadow device/head byte.
  logic [1:0] mode_q    = CFG_RST_MODE;
  logic       slave_q   = CFG_RST_SLAVE;
  logic       lba_cap_q = CFG_RST_LBA;
  logic [4:0] heads_q   = CFG_RST_HEADS;
  logic [7:0] spt_q     = CFG_RST_SPT;
  logic [7:0] shadow_q  = 8'h00;

  ata_req_t    cmd_queue[$];
  tf_write_t   expected_writes[$];
  int          mismatches = 0;
  int unsigned cycle_cnt = 0;
  logic        in_taken = 1'b0;
  logic        throttle = 1'b1;

  ata_taskfile_sequencer_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic tf_write_t wr(logic [2:0] index, logic [7:0] value);
    return '{index, value, 1'b0};
  endfunction

  // Works out the write run for one accepted beat and queues it.
  function automatic void predict_writes(ata_req_t r);
    tf_write_t   run[10];
    int          n;
    logic [31:0] heads, spt, cyl, head, sec;
    logic [7:0]  dh, lo, mid, hi, v;
    n = 0;
    if (r.action == ACT_SELECT) begin
      v = lba_cap_q ? r.sel_byte : (r.sel_byte & ~DH_LBA_BIT);
      // A select that matches the shadow byte writes nothing.
      if (v == shadow_q) return;
      run[0] = wr(REG_DEV_HEAD, v);
      n = 1;
      shadow_q = v;
    end else if (mode_q[1]) begin
      // LBA48: previous (high order) bytes first, no device/head write.
      run[0] = wr(REG_COUNT, (r.count == 8'h00) ? 8'h01 : 8'h00);
      run[1] = wr(REG_LBA_HIGH, 8'h00);
      run[2] = wr(REG_LBA_MID, 8'h00);
      run[3] = wr(REG_LBA_LOW, r.lba[31:24]);
      run[4] = wr(REG_COUNT, r.count);
      run[5] = wr(REG_LBA_HIGH, r.lba[23:16]);
      run[6] = wr(REG_LBA_MID, r.lba[15:8]);
      run[7] = wr(REG_LBA_LOW, r.lba[7:0]);
      run[8] = wr(REG_FEATURES, r.feature);
      run[9] = wr(REG_COMMAND, r.command);
      n = 10;
    end else begin
      if (mode_q == MODE_CHS) begin
        // A zero geometry value counts as one.
        heads = (heads_q == 5'd0) ? 32'd1 : 32'(heads_q);
        spt   = (spt_q == 8'd0) ? 32'd1 : 32'(spt_q);
        cyl   = r.lba / (heads * spt);
        head  = (r.lba / spt) % heads;
        sec   = (r.lba % spt) + 32'd1;
        dh    = (slave_q ? DH_CHS_SLAVE : DH_CHS_MASTER) | (head[7:0] & DH_HEAD_MASK);
        lo    = sec[7:0];
        mid   = cyl[7:0];
        hi    = cyl[15:8];
      end else begin
        dh  = (slave_q ? DH_LBA_SLAVE : DH_LBA_MASTER) | {4'h0, r.lba[27:24]};
        lo  = r.lba[7:0];
        mid = r.lba[15:8];
        hi  = r.lba[23:16];
      end
      shadow_q = dh;
      run[0] = wr(REG_DEV_HEAD, dh);
      run[1] = wr(REG_COUNT, r.count);
      run[2] = wr(REG_LBA_LOW, lo);
      run[3] = wr(REG_LBA_MID, mid);
      run[4] = wr(REG_LBA_HIGH, hi);
      run[5] = wr(REG_FEATURES, r.feature);
      run[6] = wr(REG_COMMAND, r.command);
      n = 7;
    end
    run[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_writes.push_back(run[i]);
  endfunction

  function automatic ata_req_t issue_req(logic [7:0] command, logic [31:0] lba,
                                         logic [7:0] count, logic [7:0] feature);
    ata_req_t r;
    r.action   = ACT_ISSUE;
    r.command  = command;
    r.lba      = lba;
    r.count    = count;
    r.feature  = feature;
    r.sel_byte = 8'($urandom);
    return r;
  endfunction

  function automatic ata_req_t select_req(logic [7:0] sel_byte);
    ata_req_t r;
    r = issue_req(8'($urandom), $urandom, 8'($urandom), 8'($urandom));
    r.action   = ACT_SELECT;
    r.sel_byte = sel_byte;
    return r;
  endfunction

  function automatic ata_req_t random_req();
    ata_req_t   r;
    logic [7:0] bases[4];
    bases = '{DH_CHS_MASTER, DH_CHS_SLAVE, DH_LBA_MASTER, DH_LBA_SLAVE};
    r = issue_req(8'($urandom), $urandom, 8'($urandom), 8'($urandom));
    case ($urandom_range(3))
      0: r.lba = $urandom_range(65535);
      1: r.lba = $urandom_range(1 << 22);
      default: ;
    endcase
    if ($urandom_range(9) == 0) r.count = 8'h00;
    if ($urandom_range(99) < 30) begin
      r.action = ACT_SELECT;
      // A small set of bytes makes repeats, and so skipped selects, common.
      if ($urandom_range(3) != 0)
        r.sel_byte = bases[$urandom_range(3)] | 8'($urandom_range(1));
    end
    return r;
  endfunction

  // APB write: setup cycle, then access cycle.
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      CFG_IDX_MODE:  mode_q    = value[1:0];
      CFG_IDX_SLAVE: slave_q   = value[0];
      CFG_IDX_LBA:   lba_cap_q = value[0];
      CFG_IDX_HEADS: heads_q   = value[4:0];
      CFG_IDX_SPT:   spt_q     = value[7:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [1:0] mode, logic slave, logic lba_cap,
                           logic [4:0] heads, logic [7:0] spt);
    write_reg(CFG_IDX_MODE, 32'(mode));
    write_reg(CFG_IDX_SLAVE, 32'(slave));
    write_reg(CFG_IDX_LBA, 32'(lba_cap));
    write_reg(CFG_IDX_HEADS, 32'(heads));
    write_reg(CFG_IDX_SPT, 32'(spt));
  endtask

  // Waits until every beat is sent and every write has come, then lets a
  // select with no write finish inside the block.
  task automatic drain();
    do @(posedge clk);
    while (cmd_queue.size() != 0 || in_tvalid || expected_writes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver: offers the next request once the current beat is taken.
  always @(negedge clk) begin : driver
    ata_req_t r;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (cmd_queue.size() != 0 && !(throttle && $urandom_range(99) < 17)) begin
        r = cmd_queue.pop_front();
        in_tdata  <= {r.sel_byte, r.feature, r.count, r.lba, r.command};
        in_tuser  <= r.action;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= !(throttle && $urandom_range(99) < 17);
  end

  // Monitor: predicts on each input beat and checks each output beat.
  always @(posedge clk) begin : monitor
    ata_req_t  r;
    tf_write_t got, want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      r = '{in_tuser, in_tdata[7:0], in_tdata[39:8], in_tdata[47:40],
            in_tdata[55:48], in_tdata[63:56]};
      predict_writes(r);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[2:0], out_tdata[10:3], out_tlast};
      if (expected_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected write reg %0d value %02h last %0b",
                   got.index, got.value, got.last);
      end else begin
        want = expected_writes.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR: expected reg %0d value %02h last %0b, got reg %0d value %02h last %0b",
                     want.index, want.value, want.last, got.index, got.value, got.last);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [4:0] heads;
    logic [7:0] spt;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: the shadow starts at zero, then LBA28 extremes.
    cmd_queue.push_back(select_req(8'h00));
    cmd_queue.push_back(issue_req(8'h00, 32'h0000_0000, 8'h00, 8'h00));
    cmd_queue.push_back(issue_req(8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
    cmd_queue.push_back(select_req(8'hEF));
    cmd_queue.push_back(select_req(8'h00));
    cmd_queue.push_back(select_req(8'h00));
    cmd_queue.push_back(select_req(8'hFF));
    drain();

    // CHS at the usual geometry, including cylinder overflow.
    configure(MODE_CHS, 1'b1, 1'b1, 5'd16, 8'd63);
    cmd_queue.push_back(issue_req(8'h20, 32'd0, 8'd1, 8'h00));
    cmd_queue.push_back(issue_req(8'h30, 32'd1007, 8'd8, 8'h03));
    cmd_queue.push_back(issue_req(8'hC8, 32'hFFFF_FFFF, 8'h00, 8'hFF));
    drain();

    // Smallest geometry.
    configure(MODE_CHS, 1'b0, 1'b1, 5'd1, 8'd1);
    cmd_queue.push_back(issue_req(8'h20, 32'h0001_2345, 8'd2, 8'h00));
    cmd_queue.push_back(issue_req(8'h20, 32'hFFFF_FFFF, 8'd2, 8'h00));
    drain();

    // Zero geometry counts as one.
    configure(MODE_CHS, 1'b0, 1'b1, 5'd0, 8'd0);
    cmd_queue.push_back(issue_req(8'h20, 32'd1000, 8'd3, 8'h11));
    drain();

    // Head count beyond sixteen: the head number is masked to four bits.
    configure(MODE_CHS, 1'b1, 1'b1, 5'd31, 8'd255);
    cmd_queue.push_back(issue_req(8'h24, 32'hFFFF_FFFF, 8'd4, 8'h22));
    cmd_queue.push_back(issue_req(8'h24, 32'h1234_5678, 8'd5, 8'h33));
    drain();

    // LBA48 with both count extremes; a non-LBA drive drops bit 6 on select.
    configure(MODE_LBA48, 1'b1, 1'b0, 5'd16, 8'd63);
    cmd_queue.push_back(issue_req(8'h25, 32'h0000_0000, 8'h00, 8'h00));
    cmd_queue.push_back(issue_req(8'h35, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
    cmd_queue.push_back(select_req(8'hF5));
    cmd_queue.push_back(select_req(8'hB5));
    drain();

    // Mode three behaves as LBA48; then LBA28 on the slave drive.
    configure(MODE_WIDE, 1'b0, 1'b1, 5'd16, 8'd63);
    cmd_queue.push_back(issue_req(8'h25, 32'h89AB_CDEF, 8'h10, 8'h5A));
    drain();
    configure(MODE_LBA28, 1'b1, 1'b1, 5'd16, 8'd63);
    cmd_queue.push_back(issue_req(8'hCA, 32'h0A00_0000, 8'h80, 8'hA5));
    drain();

    // Random phases under random settings; one phase runs without stalls.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      throttle = (phase != RAND_PHASES / 2);
      heads = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(1, 16));
      spt   = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      configure(2'($urandom_range(3)), 1'($urandom), 1'($urandom), heads, spt);
      repeat (PHASE_ITEMS) cmd_queue.push_back(random_req());
      drain();
    end

    if (expected_writes.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
